// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked property, checked during reset as well
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== src/fed_pkg.sv =====
// ----------------------------------------------------------------------------
// fed_pkg
// Types and constants of the feedback echo delay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fed_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_Q8      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd4;

  localparam logic        RST_ENABLE        = 1'b0;
  localparam logic [24:0] RST_DELAY_Q8      = 25'd4300800;
  localparam logic [15:0] RST_WET_GAIN      = 16'd11469;
  localparam logic [15:0] RST_DRY_GAIN      = 16'd32768;
  localparam logic [14:0] RST_FEEDBACK_GAIN = 15'd16384;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
  } sample_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
  } result_item_t;

endpackage

`default_nettype wire

// ===== src/fed_ram.sv =====
// ----------------------------------------------------------------------------
// fed_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== src/feedback_echo_delay.sv =====
// ----------------------------------------------------------------------------
// feedback_echo_delay
// Stereo echo with feedback over a circular delay memory, linear interpolation
// between neighboring entries, one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel   | handshake                   | payload
//  sample    | sample_valid / sample_stall | sample_item (sample_left, right)
//  result    | result_valid / result_stall | result_item (out_left, out_right)
//  config    | cfg_write                   | cfg_index, cfg_data
//
//  Enabled item: address and read steps, then 8 steps per channel on the
//  single 17x17 multiplier. Disabled item: straight to the done state.
//  After reset a clearing pass writes zero to every entry, sample_stall held
//  high meanwhile. A waiting result is held in an output register; the next
//  item is taken while it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module feedback_echo_delay
  import fed_pkg::*;
#(
  parameter int DEPTH    = 131072,
  parameter int CHANNELS = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  sample_valid,
  output logic                       sample_stall,
  input  wire sample_item_t          sample_item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_item_t               result_item,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = AW + 9;
  localparam int CW    = (RW > 25) ? RW : 25;
  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ACC_W = 35;
  localparam int PROD_W = 34;
  localparam int SPAN_I = DEPTH * 256;
  localparam int DMAX_I = (DEPTH - 1) * 256;

  localparam logic [RW-1:0]  SPAN     = RW'(SPAN_I);
  localparam logic [CW-1:0]  DMAX     = CW'(DMAX_I);
  localparam logic [CW-1:0]  DMIN     = CW'(256);
  localparam logic [AW-1:0]  LAST     = AW'(DEPTH - 1);
  localparam logic [CHW-1:0] LAST_CH  = CHW'(CHANNELS - 1);

  typedef enum logic [14:0] {
    S_CLR  = 15'b000000000000001,
    S_IDLE = 15'b000000000000010,
    S_ADDR = 15'b000000000000100,
    S_RDA  = 15'b000000000001000,
    S_RDB  = 15'b000000000010000,
    S_RDC  = 15'b000000000100000,
    S_P0   = 15'b000000001000000,
    S_P1   = 15'b000000010000000,
    S_P2   = 15'b000000100000000,
    S_P3   = 15'b000001000000000,
    S_P4   = 15'b000010000000000,
    S_P5   = 15'b000100000000000,
    S_P6   = 15'b001000000000000,
    S_P7   = 15'b010000000000000,
    S_DONE = 15'b100000000000000
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > 35'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -35'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  state_t state, state_next;

  logic        enable;
  logic [24:0] delay_q8;
  logic [15:0] wet_gain;
  logic [15:0] dry_gain;
  logic [14:0] feedback_gain;

  logic [AW-1:0]  wp;
  logic [AW-1:0]  clr_addr;
  logic [RW-1:0]  rpos;
  logic [AW-1:0]  ib;
  logic [7:0]     frac;
  logic [CHW-1:0] ch;
  logic           echo_on;

  logic signed [15:0] dry [2];
  logic signed [15:0] res [2];
  logic signed [15:0] a_q [CHANNELS];
  logic signed [15:0] b_q [CHANNELS];
  logic signed [15:0] delayed;

  logic signed [16:0]       opa, opb;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [15:0]       delayed_c;
  logic signed [15:0]       mem_wdata;

  logic [CW-1:0] d_ext, d_sel;
  logic [RW-1:0] rwrap;
  logic [AW-1:0] ia;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic [15:0]   rd_data [CHANNELS];

  logic accept;
  logic out_free;

  assign accept       = sample_valid && (state == S_IDLE);
  assign sample_stall = (state != S_IDLE);
  assign out_free     = !result_valid || !result_stall;

  // delay clamp and read position
  assign d_ext = CW'(delay_q8);
  always_comb begin
    priority if (d_ext < DMIN) begin
      d_sel = DMIN;
    end else if (d_ext > DMAX) begin
      d_sel = DMAX;
    end else begin
      d_sel = d_ext;
    end
  end

  assign rwrap = (rpos >= SPAN) ? (rpos - SPAN) : rpos;
  assign ia    = rwrap[AW+7:8];

  assign rd_addr = (state == S_RDA) ? ia : ib;
  assign wr_addr = (state == S_CLR) ? clr_addr : wp;
  assign wr_data = (state == S_CLR) ? 16'h0000 : mem_wdata;

  // shared multiplier operands
  assign delayed_c = acc[23:8];
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (state)
      S_P0: begin
        opa = {a_q[ch][15], a_q[ch]};
        opb = {8'b0, 9'(9'd256 - {1'b0, frac})};
      end
      S_P1: begin
        opa = {b_q[ch][15], b_q[ch]};
        opb = {9'b0, frac};
      end
      S_P3: begin
        opa = {delayed_c[15], delayed_c};
        opb = {2'b0, feedback_gain};
      end
      S_P4: begin
        opa = {dry[ch][15], dry[ch]};
        opb = {1'b0, dry_gain};
      end
      S_P5: begin
        opa = {delayed[15], delayed};
        opb = {1'b0, wet_gain};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_ext  = {prod[PROD_W-1], prod};
  assign mem_wdata = sat16($signed({{(ACC_W-16){dry[ch][15]}}, dry[ch]}) + (acc >>> 15));

  for (genvar i = 0; i < CHANNELS; i++) begin : g_mem
    fed_ram #(
      .WIDTH(16),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk    (clk),
      .wr_en  ((state == S_CLR) || ((state == S_P5) && (ch == CHW'(i)))),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data[i])
    );
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:  if (clr_addr == LAST) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) state_next = enable ? S_ADDR : S_DONE;
      end
      S_ADDR: state_next = S_RDA;
      S_RDA:  state_next = S_RDB;
      S_RDB:  state_next = S_RDC;
      S_RDC:  state_next = S_P0;
      S_P0:   state_next = S_P1;
      S_P1:   state_next = S_P2;
      S_P2:   state_next = S_P3;
      S_P3:   state_next = S_P4;
      S_P4:   state_next = S_P5;
      S_P5:   state_next = S_P6;
      S_P6:   state_next = S_P7;
      S_P7:   state_next = (ch == LAST_CH) ? S_DONE : S_P0;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_addr      <= '0;
      wp            <= '0;
      ch            <= '0;
      echo_on       <= 1'b0;
      result_valid  <= 1'b0;
      enable        <= RST_ENABLE;
      delay_q8      <= RST_DELAY_Q8;
      wet_gain      <= RST_WET_GAIN;
      dry_gain      <= RST_DRY_GAIN;
      feedback_gain <= RST_FEEDBACK_GAIN;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        unique case (cfg_index)
          CFG_ENABLE:        enable        <= cfg_data[0];
          CFG_DELAY_Q8:      delay_q8      <= cfg_data[24:0];
          CFG_WET_GAIN:      wet_gain      <= cfg_data[15:0];
          CFG_DRY_GAIN:      dry_gain      <= cfg_data[15:0];
          CFG_FEEDBACK_GAIN: feedback_gain <= cfg_data[14:0];
          default: ;
        endcase
      end

      if (state == S_CLR) begin
        clr_addr <= clr_addr + 1'b1;
      end

      if (accept) begin
        echo_on <= enable;
        ch      <= '0;
      end

      if ((state == S_P7) && (ch != LAST_CH)) begin
        ch <= ch + 1'b1;
      end

      if ((state == S_DONE) && out_free) begin
        result_valid <= 1'b1;
        if (echo_on) begin
          wp <= (wp == LAST) ? '0 : wp + 1'b1;
        end
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      dry[0] <= sample_item.sample_left;
      dry[1] <= sample_item.sample_right;
      res[0] <= sample_item.sample_left;
      res[1] <= sample_item.sample_right;
    end

    if (state == S_ADDR) begin
      rpos <= {1'b0, wp, 8'h00} + SPAN - d_sel[RW-1:0];
    end

    if (state == S_RDA) begin
      ib   <= (ia == LAST) ? '0 : ia + 1'b1;
      frac <= rwrap[7:0];
    end

    for (int i = 0; i < CHANNELS; i++) begin
      if (state == S_RDB) a_q[i] <= rd_data[i];
      if (state == S_RDC) b_q[i] <= rd_data[i];
    end

    prod <= opa * opb;

    unique case (state)
      S_P1: acc <= prod_ext + 35'sd128;
      S_P2: acc <= acc + prod_ext;
      S_P3: delayed <= delayed_c;
      S_P4: acc <= prod_ext + 35'sd16384;
      S_P5: acc <= prod_ext + 35'sd16384;
      S_P6: acc <= acc + prod_ext;
      S_P7: res[ch] <= sat16(acc >>> 15);
      default: ;
    endcase

    if ((state == S_DONE) && out_free) begin
      result_item.out_left  <= res[0];
      result_item.out_right <= res[1];
    end
  end

endmodule

`default_nettype wire

// ===== src/fed_checker.sv =====
// ----------------------------------------------------------------------------
// fed_checker
// Port-level checks on the feedback echo delay, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fed_checker
  import fed_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         sample_valid,
  input wire logic         sample_stall,
  input wire logic         result_valid,
  input wire logic         result_stall,
  input wire result_item_t result_item
);

  `ASSERT_CLK(a_result_holds, clk, rst, result_valid && result_stall |=> result_valid)
  `ASSERT_CLK(a_result_stable, clk, rst, result_valid && result_stall |=> $stable(result_item))
  // one item at a time: busy right after an item is taken
  `ASSERT_CLK(a_busy_after_item, clk, rst, sample_valid && !sample_stall |=> sample_stall)
  // memory clear follows reset
  `ASSERT_CLK_ALWAYS(a_clear_after_rst, clk, rst |=> sample_stall && !result_valid)

endmodule

bind feedback_echo_delay fed_checker u_fed_checker (
  .clk         (clk),
  .rst         (rst),
  .sample_valid(sample_valid),
  .sample_stall(sample_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result_item (result_item)
);

`default_nettype wire
